>>> design/abp_pkg.sv
// Shared constants, types and control codes for the AABB broadphase pair finder.
`timescale 1ns / 1ps

package abp_pkg;

   localparam int MAX_BOXES_DEF  = 64;
   localparam int COORD_BITS_DEF = 24;
   localparam int ID_W           = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_TAIL,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

>>> design/aabb_broadphase_pair_finder.sv
// Top level: box ring of cells, one overlap tester at the ring head, pair sequencer.
// With a non-empty store the block stays busy through one full turn of the ring past the single
// comparator, then the tail and last states; the final pair appears in the cycle busy falls.
// A new box is taken only while idle; one that starts a new set or meets an empty store skips
// the sweep and goes straight to the store.
// Reset empties the store and clears the sequencer; results cannot be stalled.
`timescale 1ns / 1ps

module aabb_broadphase_pair_finder
   import abp_pkg::*;
#(
   parameter int MAX_BOXES  = MAX_BOXES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_new_set,
   input  logic [ID_W-1:0]              req_box_id,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic [COORD_BITS-2:0]        req_size_x,
   input  logic [COORD_BITS-2:0]        req_size_y,
   input  logic [COORD_BITS-2:0]        req_size_z,
   output logic                         rsp_strobe,
   output logic [ID_W-1:0]              rsp_first_id,
   output logic [ID_W-1:0]              rsp_second_id,
   output logic                         rsp_last_pair
);

   localparam int BW     = COORD_BITS + 2;
   localparam int DATA_W = ID_W + 6 * BW;
   localparam int IDX_W  = $clog2(MAX_BOXES);
   localparam int CNT_W  = $clog2(MAX_BOXES + 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pair_cnt_ff, pair_cnt_in;
   logic [DATA_W-1:0] q_data_ff, q_data_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_first_ff, pend_first_in;
   logic [ID_W-1:0]   pend_second_ff, pend_second_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [ID_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [ID_W-1:0]   rsp_second_ff, rsp_second_in;

   logic              shift_en;
   logic              store_en;
   logic              cmp_en;
   logic              hit;
   logic [ID_W-1:0]   hit_first, hit_second;
   logic [DATA_W-1:0] new_box;
   logic [DATA_W-1:0] ring [MAX_BOXES];

   // doubled bounds: 2p - s and 2p + s
   function automatic logic [BW-1:0] bound(input logic signed [COORD_BITS-1:0] pos,
                                           input logic [COORD_BITS-2:0] size,
                                           input logic upper);
      logic signed [BW-1:0] p2;
      logic signed [BW-1:0] sz;
      p2 = signed'({pos[COORD_BITS-1], pos, 1'b0});
      sz = signed'({3'b000, size});
      return upper ? BW'(p2 + sz) : BW'(p2 - sz);
   endfunction

   assign new_box = {req_box_id,
                     bound(req_pos_x, req_size_x, 1'b0), bound(req_pos_x, req_size_x, 1'b1),
                     bound(req_pos_y, req_size_y, 1'b0), bound(req_pos_y, req_size_y, 1'b1),
                     bound(req_pos_z, req_size_z, 1'b0), bound(req_pos_z, req_size_z, 1'b1)};

   // ring of cells: cell 0 is the head, each cell takes its upper neighbour's box
   for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_BOXES;
      cell_ctl_type ctl;

      assign ctl.shift = shift_en;
      assign ctl.load  = store_en && (count_ff == CNT_W'(k));

      abp_cell #(
         .DATA_W(DATA_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .shift_data(ring[NEXT]),
         .load_data (q_data_ff),
         .data      (ring[k])
      );
   end

   assign cmp_en = (state_ff == ST_SWEEP) && (CNT_W'(idx_ff) < count_ff);

   abp_overlap #(
      .COORD_BITS(COORD_BITS)
   ) u_overlap (
      .clock    (clock),
      .reset    (reset),
      .enable   (cmp_en),
      .query    (q_data_ff),
      .stored   (ring[0]),
      .hit      (hit),
      .first_id (hit_first),
      .second_id(hit_second)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         pair_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         pair_cnt_ff   <= pair_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      q_data_ff      <= q_data_in;
      pend_first_ff  <= pend_first_in;
      pend_second_ff <= pend_second_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_second_ff  <= rsp_second_in;
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      pair_cnt_in    = pair_cnt_ff;
      q_data_in      = q_data_ff;
      pend_valid_in  = pend_valid_ff;
      pend_first_in  = pend_first_ff;
      pend_second_in = pend_second_ff;
      rsp_strobe_in  = 1'b0;
      rsp_last_in    = 1'b0;
      rsp_first_in   = rsp_first_ff;
      rsp_second_in  = rsp_second_ff;
      shift_en       = 1'b0;
      store_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               q_data_in     = new_box;
               idx_in        = '0;
               pair_cnt_in   = '0;
               pend_valid_in = 1'b0;
               if (req_new_set) begin
                  count_in = '0;
               end
               // nothing to test against: go straight to the store
               if (req_new_set || count_ff == '0) begin
                  state_in = ST_LAST;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            // one full turn brings every box back to its own cell
            shift_en = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(MAX_BOXES - 1)) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_LAST;
         end
         ST_LAST: begin
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_first_in  = pend_first_ff;
               rsp_second_in = pend_second_ff;
               pend_valid_in = 1'b0;
            end
            if (count_ff < CNT_W'(MAX_BOXES)) begin
               store_en = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold one pair back so the final one of a run can be marked; drop past the cap
      if (hit && pair_cnt_ff != IDX_W'(MAX_BOXES - 1)) begin
         pair_cnt_in    = pair_cnt_ff + 1'b1;
         pend_valid_in  = 1'b1;
         pend_first_in  = hit_first;
         pend_second_in = hit_second;
         if (pend_valid_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b0;
            rsp_first_in  = pend_first_ff;
            rsp_second_in = pend_second_ff;
         end
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_first_id  = rsp_first_ff;
   assign rsp_second_id = rsp_second_ff;
   assign rsp_last_pair = rsp_last_ff;

endmodule

>>> design/abp_cell.sv
// One storage cell of the box ring: holds a stored box and passes it to its neighbour.
`timescale 1ns / 1ps

module abp_cell
   import abp_pkg::*;
#(
   parameter int DATA_W = ID_W + 6 * (COORD_BITS_DEF + 2)
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] shift_data,
   input  logic [DATA_W-1:0] load_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> design/abp_overlap.sv
// Registered three-axis overlap test of the query box against the box at the ring head.
`timescale 1ns / 1ps

module abp_overlap
   import abp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    enable,
   input  logic [ID_W+6*(COORD_BITS+2)-1:0]        query,
   input  logic [ID_W+6*(COORD_BITS+2)-1:0]        stored,
   output logic                                    hit,
   output logic [ID_W-1:0]                         first_id,
   output logic [ID_W-1:0]                         second_id
);

   localparam int BW     = COORD_BITS + 2;
   localparam int DATA_W = ID_W + 6 * BW;

   logic [ID_W-1:0]      q_id, s_id;
   logic signed [BW-1:0] q_mnx, q_mxx, q_mny, q_mxy, q_mnz, q_mxz;
   logic signed [BW-1:0] s_mnx, s_mxx, s_mny, s_mxy, s_mnz, s_mxz;
   logic                 meet;

   logic            hit_ff, hit_in;
   logic [ID_W-1:0] first_ff, first_in;
   logic [ID_W-1:0] second_ff, second_in;

   assign q_id  = query[DATA_W-1 -: ID_W];
   assign q_mnx = signed'(query[6*BW-1 -: BW]);
   assign q_mxx = signed'(query[5*BW-1 -: BW]);
   assign q_mny = signed'(query[4*BW-1 -: BW]);
   assign q_mxy = signed'(query[3*BW-1 -: BW]);
   assign q_mnz = signed'(query[2*BW-1 -: BW]);
   assign q_mxz = signed'(query[BW-1:0]);

   assign s_id  = stored[DATA_W-1 -: ID_W];
   assign s_mnx = signed'(stored[6*BW-1 -: BW]);
   assign s_mxx = signed'(stored[5*BW-1 -: BW]);
   assign s_mny = signed'(stored[4*BW-1 -: BW]);
   assign s_mxy = signed'(stored[3*BW-1 -: BW]);
   assign s_mnz = signed'(stored[2*BW-1 -: BW]);
   assign s_mxz = signed'(stored[BW-1:0]);

   // inclusive interval overlap on every axis
   assign meet = (q_mnx <= s_mxx) && (q_mxx >= s_mnx) &&
                 (q_mny <= s_mxy) && (q_mxy >= s_mny) &&
                 (q_mnz <= s_mxz) && (q_mxz >= s_mnz);

   always_comb begin
      hit_in = enable && meet;
      // stored box leads on equal minimum x
      if (q_mnx < s_mnx) begin
         first_in  = q_id;
         second_in = s_id;
      end else begin
         first_in  = s_id;
         second_in = q_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign hit       = hit_ff;
   assign first_id  = first_ff;
   assign second_id = second_ff;

endmodule

>>> design/abp_checker.sv
// Port-level checks on the pair finder's command and result sequencing, bound to the top.
`timescale 1ns / 1ps

module abp_checker
   import abp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_strobe,
   input logic            rsp_last_pair,
   input logic [ID_W-1:0] rsp_first_id,
   input logic [ID_W-1:0] rsp_second_id
);

   // every transfer makes the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer did not raise busy");

   // a new transfer never produces a pair in the following cycle
   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("pair right after a transfer");

   // a pair that is not the last one of a run is followed by more work or the final pair
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_pair |=> (busy || rsp_strobe))
      else $error("run ended without a marked final pair");

   // the final pair of a run stands alone
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_pair |=> !rsp_strobe)
      else $error("pair after the final pair of a run");

   // result ids are never unknown while strobed
   a_ids_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown({rsp_first_id, rsp_second_id}))
      else $error("unknown id on a strobed pair");

endmodule

bind aabb_broadphase_pair_finder abp_checker u_abp_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_last_pair(rsp_last_pair),
   .rsp_first_id (rsp_first_id),
   .rsp_second_id(rsp_second_id)
);
